FILE: hdl/next_probable_prime_search_unit_assert.svh
// ----------------------------------------------------------------------------
// next probable prime search unit - assertion macros
// concurrent checks on clock, disabled during reset
// ----------------------------------------------------------------------------
`ifndef NEXT_PROBABLE_PRIME_SEARCH_UNIT_ASSERT_SVH
`define NEXT_PROBABLE_PRIME_SEARCH_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define NPPS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define NPPS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NPPS_ASSERT_NOW(lbl, ante, cons, msg)
`define NPPS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hdl/npps_pkg.sv
// ----------------------------------------------------------------------------
// npps_pkg
// shared widths, types and controller/datapath command and status structs
// ----------------------------------------------------------------------------
`default_nettype none
package npps_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int FIELD_W     = 32;
   localparam int BIT_W       = $clog2(VALUE_WIDTH);

   typedef logic [VALUE_WIDTH-1:0] val_type;
   typedef logic [BIT_W-1:0]       bit_idx_type;

   typedef struct packed {
      logic load;
      logic exp_init;
      logic exp_next;
      logic mul_step;
      logic dbl;
      logic advance;
      logic finish_pass;
      logic finish_ovf;
   } cmd_type;

   typedef struct packed {
      logic cand_is_one;
      logic cand_is_top;
      logic mul_last;
      logic exp_bit;
      logic exp_last;
      logic acc_is_one;
   } status_type;
endpackage
`default_nettype wire

FILE: hdl/npps_datapath.sv
// ----------------------------------------------------------------------------
// npps_datapath
// candidate, exponent and accumulator registers with a bit-serial modular
// multiplier
// ----------------------------------------------------------------------------
`default_nettype none
`include "next_probable_prime_search_unit_assert.svh"
module npps_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [npps_pkg::FIELD_W-1:0]  req_start_value,
   input  wire npps_pkg::cmd_type             cmd,
   output npps_pkg::status_type               status,
   output logic                               rsp_valid,
   output logic [npps_pkg::FIELD_W-1:0]       rsp_probable_prime,
   output logic                               rsp_search_overflow
);
   import npps_pkg::*;

   localparam bit_idx_type TOP_BIT = bit_idx_type'(VALUE_WIDTH - 1);

   val_type                cand_ff, cand_in;
   val_type                exp_ff, exp_in;
   val_type                acc_ff, acc_in;
   val_type                r_ff, r_in;
   bit_idx_type            mbit_ff, mbit_in;
   bit_idx_type            ebit_ff, ebit_in;
   val_type                res_ff, res_in;
   logic                   ovf_ff, ovf_in;
   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH:0]   t1, t2, td;
   logic [VALUE_WIDTH:0]   cw;

   always_comb begin
      cw = {1'b0, cand_ff};
      // one multiplier bit: r = 2r + bit*acc, reduced after each add
      t1 = {r_ff, 1'b0};
      if (t1 >= cw) begin
         t1 = t1 - cw;
      end
      t2 = t1 + (acc_ff[mbit_ff] ? {1'b0, acc_ff} : '0);
      if (t2 >= cw) begin
         t2 = t2 - cw;
      end
      td = {acc_ff, 1'b0};
      if (td >= cw) begin
         td = td - cw;
      end
   end

   always_comb begin
      cand_in  = cand_ff;
      exp_in   = exp_ff;
      acc_in   = acc_ff;
      r_in     = r_ff;
      mbit_in  = mbit_ff;
      ebit_in  = ebit_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;
      valid_in = 1'b0;
      if (cmd.load) begin
         cand_in = req_start_value[VALUE_WIDTH-1:0];
         if (cand_in == '0) begin
            cand_in = val_type'(1);
         end
      end
      if (cmd.advance) begin
         cand_in = cand_ff + val_type'(1);
      end
      if (cmd.exp_init) begin
         exp_in  = cand_ff - val_type'(1);
         ebit_in = TOP_BIT;
         acc_in  = val_type'(1);
         r_in    = '0;
         mbit_in = TOP_BIT;
      end
      if (cmd.exp_next) begin
         ebit_in = ebit_ff - bit_idx_type'(1);
         r_in    = '0;
         mbit_in = TOP_BIT;
      end
      if (cmd.mul_step) begin
         r_in    = t2[VALUE_WIDTH-1:0];
         mbit_in = mbit_ff - bit_idx_type'(1);
         if (mbit_ff == '0) begin
            acc_in = t2[VALUE_WIDTH-1:0];
         end
      end
      if (cmd.dbl) begin
         acc_in = td[VALUE_WIDTH-1:0];
      end
      if (cmd.finish_pass) begin
         res_in   = cand_ff;
         ovf_in   = 1'b0;
         valid_in = 1'b1;
      end
      if (cmd.finish_ovf) begin
         res_in   = '0;
         ovf_in   = 1'b1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      exp_ff  <= exp_in;
      acc_ff  <= acc_in;
      r_ff    <= r_in;
      mbit_ff <= mbit_in;
      ebit_ff <= ebit_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      status.cand_is_one = (cand_ff == val_type'(1));
      status.cand_is_top = (cand_ff == '1);
      status.mul_last    = (mbit_ff == '0);
      status.exp_bit     = exp_ff[ebit_ff];
      status.exp_last    = (ebit_ff == '0);
      status.acc_is_one  = (acc_ff == val_type'(1));
   end

   assign rsp_valid           = valid_ff;
   assign rsp_probable_prime  = FIELD_W'(res_ff);
   assign rsp_search_overflow = ovf_ff;

   `NPPS_ASSERT_NOW(a_ovf_zero, valid_ff && ovf_ff, res_ff == '0, "overflow with nonzero value")
   `NPPS_ASSERT_NEXT(a_load_nonzero, cmd.load, cand_ff != '0, "candidate zero after load")
   `NPPS_ASSERT_NEXT(a_mul_reduced, cmd.mul_step, r_ff < cand_ff, "partial product not reduced")
endmodule
`default_nettype wire

FILE: hdl/npps_controller.sv
// ----------------------------------------------------------------------------
// npps_controller
// sequences candidates, exponent bits and multiplier steps
// ----------------------------------------------------------------------------
`default_nettype none
`include "next_probable_prime_search_unit_assert.svh"
module npps_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire npps_pkg::status_type  status,
   output npps_pkg::cmd_type          cmd
);
   import npps_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_SQ     = 6'b000100,
      S_DBL    = 6'b001000,
      S_BITEND = 6'b010000,
      S_TEST   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // one passes with the empty power
            if (status.cand_is_one) begin
               cmd.finish_pass = 1'b1;
               state_in        = S_IDLE;
            end else begin
               cmd.exp_init = 1'b1;
               state_in     = S_SQ;
            end
         end
         S_SQ: begin
            cmd.mul_step = 1'b1;
            if (status.mul_last) begin
               state_in = status.exp_bit ? S_DBL : S_BITEND;
            end
         end
         S_DBL: begin
            cmd.dbl  = 1'b1;
            state_in = S_BITEND;
         end
         S_BITEND: begin
            if (status.exp_last) begin
               state_in = S_TEST;
            end else begin
               cmd.exp_next = 1'b1;
               state_in     = S_SQ;
            end
         end
         S_TEST: begin
            if (status.acc_is_one) begin
               cmd.finish_pass = 1'b1;
               state_in        = S_IDLE;
            end else if (status.cand_is_top) begin
               cmd.finish_ovf = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `NPPS_ASSERT_NEXT(a_start_taken, state_ff == S_IDLE && start, state_ff == S_CHECK, "start lost")
   `NPPS_ASSERT_NOW(a_one_finish, cmd.finish_pass, !cmd.finish_ovf, "two finishes")
   `NPPS_ASSERT_NEXT(a_finish_idle, cmd.finish_pass || cmd.finish_ovf, !busy, "busy after finish")
endmodule
`default_nettype wire

FILE: hdl/next_probable_prime_search_unit.sv
// ----------------------------------------------------------------------------
// next_probable_prime_search_unit
// smallest value at or above a start that passes 2^(n-1) mod n == 1
// ----------------------------------------------------------------------------
// pulse start while busy is low to hand in one item; the result shows on the
// rsp_ ports for exactly one cycle with rsp_valid high and cannot be stalled,
// so the receiver must take it then. the bit-serial modular multiplier does
// one multiplier bit per cycle for each of the VALUE_WIDTH squarings of a
// candidate, and candidates are tried in turn until one passes. a start of
// zero is taken as one, one passes, two fails, base-2 pseudoprimes pass.
// running past the all-ones value gives a result of zero with
// rsp_search_overflow set.
`default_nettype none
module next_probable_prime_search_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [npps_pkg::FIELD_W-1:0]  req_start_value,
   output logic                               rsp_valid,
   output logic [npps_pkg::FIELD_W-1:0]       rsp_probable_prime,
   output logic                               rsp_search_overflow
);
   import npps_pkg::*;

   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   npps_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   npps_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_start_value     (req_start_value),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_probable_prime  (rsp_probable_prime),
      .rsp_search_overflow (rsp_search_overflow)
   );
endmodule
`default_nettype wire

FILE: tb/next_probable_prime_search_unit_tb.sv
// ----------------------------------------------------------------------------
// next_probable_prime_search_unit_tb
// self-checking bench for the base-2 fermat next probable prime search
// ----------------------------------------------------------------------------
// items go in on the start/busy handshake. every accepted item gets its
// expected result from a software fermat search kept in this file. each
// rsp_valid pulse is compared against the oldest pending expectation.
// ----------------------------------------------------------------------------
`default_nettype none
module next_probable_prime_search_unit_tb;
   import npps_pkg::*;

   // the bound is a kill switch only
   localparam longint unsigned CYCLE_LIMIT = 64'd60_000_000;
   localparam int DRAIN_CYCLES = 3000;

   typedef struct {
      logic [FIELD_W-1:0] prime;
      logic               overflow;
   } prime_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FIELD_W-1:0] req_start_value = '0;
   logic rsp_valid;
   logic [FIELD_W-1:0] rsp_probable_prime;
   logic rsp_search_overflow;

   prime_result_type pending_primes[$];
   int error_count = 0;
   longint unsigned cycle_count = 0;

   next_probable_prime_search_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_start_value     (req_start_value),
      .rsp_valid           (rsp_valid),
      .rsp_probable_prime  (rsp_probable_prime),
      .rsp_search_overflow (rsp_search_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // 2^(c-1) mod c == 1; one passes since the empty power is never reduced
   function automatic bit fermat_base2(input longint unsigned c);
      longint unsigned acc;
      longint unsigned pw;
      longint unsigned e;
      acc = 1;
      pw  = 2;
      if (c <= 1) return 1'b1;
      e = c - 1;
      while (e != 0) begin
         if (e[0]) acc = (acc * pw) % c;
         pw = (pw * pw) % c;
         e  = e >> 1;
      end
      return acc == 1;
   endfunction

   // upward search from the start, zero taken as one, overflow past all-ones
   function automatic prime_result_type search_prime(input logic [FIELD_W-1:0] sv);
      longint unsigned top;
      longint unsigned c;
      prime_result_type r;
      top = (64'd1 << VALUE_WIDTH) - 1;
      c   = longint'(sv) & top;
      r.prime    = '0;
      r.overflow = 1'b1;
      if (c == 0) c = 1;
      forever begin
         if (fermat_base2(c)) begin
            r.prime    = c[FIELD_W-1:0];
            r.overflow = 1'b0;
            break;
         end
         if (c >= top) break;
         c++;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                  input logic [FIELD_W-1:0] want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d", what, got, want);
   endtask

   // one item: random gap, then hold start until an edge sees busy low
   task automatic send_item(input logic [FIELD_W-1:0] sv);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_start_value <= sv;
      do @(posedge clock); while (busy);
      // accepted at this edge
      pending_primes.push_back(search_prime(sv));
   endtask

   // sender holds off until every expected result is back
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_primes.size() != 0) @(posedge clock);
   endtask

   // result checker; the receiver has no way to stall
   always @(posedge clock) begin
      prime_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_primes.size() == 0) begin
            report_mismatch("unexpected item", rsp_probable_prime, '0);
         end else begin
            want = pending_primes.pop_front();
            if (rsp_probable_prime !== want.prime)
               report_mismatch("probable_prime", rsp_probable_prime, want.prime);
            if (rsp_search_overflow !== want.overflow)
               report_mismatch("search_overflow", FIELD_W'(rsp_search_overflow),
                               FIELD_W'(want.overflow));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // zero, one, two and the first small values
   task automatic test_small_edges();
      send_item(32'd0);
      send_item(32'd1);
      send_item(32'd2);
      send_item(32'd3);
      send_item(32'd4);
      send_item(32'd24);
   endtask

   // base-2 pseudoprimes pass the test
   task automatic test_pseudoprimes();
      send_item(32'd340);
      send_item(32'd341);
      send_item(32'd561);
      send_item(32'd645);
   endtask

   // wide values: msb set, mersenne prime, near and past the last prime
   task automatic test_wide_values();
      send_item(32'h8000_0000);
      send_item(32'h7FFF_FFFF);
      send_item(32'hFFFF_FFF0);
      send_item(32'hFFFF_FFFB);
      send_item(32'hFFFF_FFFC);
      send_item(32'hFFFF_FFFF);
      send_item(32'hAAAA_AAAA);
      send_item(32'h5555_5555);
   endtask

   // mostly small starts keep the run short; a few full width and near the top
   task automatic test_random_starts(input int count);
      int sel;
      logic [FIELD_W-1:0] sv;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 65)      sv = $urandom_range(0, 65535);
         else if (sel < 85) sv = $urandom;
         else               sv = 32'hFFFF_FFFF - $urandom_range(0, 400);
         send_item(sv);
         if (i == count / 2) wait_drained();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_edges();
      test_pseudoprimes();
      wait_drained();
      test_wide_values();
      test_random_starts(100);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
